// File: rtl/core/bpec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpec_pkg
// Shared types and constants for the bit-parallel edit column engine.
// ----------------------------------------------------------------------------
package bpec_pkg;

   localparam int WINDOW_BLOCKS_DEF = 8;
   localparam int WORD_W            = 64;
   localparam int IDX_W             = 3;
   localparam int SYM_W             = 2;
   localparam int CMD_W             = 2;
   localparam int SYMBOLS           = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_START   = 2'd1,
      CMD_ADVANCE = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] pv;
      logic [WORD_W-1:0] mv;
      logic              carry_pos;
      logic              carry_neg;
   } step_type;

endpackage
`default_nettype wire

// File: rtl/core/bit_parallel_edit_column_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bit_parallel_edit_column_engine
// Myers bit-parallel edit-distance column engine over a window of blocks.
// ----------------------------------------------------------------------------
// Load and start requests give no response. An advance request first reads
// block 0 from the equality and vector RAMs, then steps one block per cycle
// while the response register is free, paced by the registered RAM read and
// the horizontal carry passed from block to block. Responses come out in
// block order through an output register, so the next request is taken
// while the last response still waits; a stalled response port holds the
// block sequence. Vector RAM entries not yet written since a start read
// as +1 all ones and -1 zero via per-block valid bits.
// ----------------------------------------------------------------------------
module bit_parallel_edit_column_engine #(
   parameter int WINDOW_BLOCKS = bpec_pkg::WINDOW_BLOCKS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [bpec_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic [bpec_pkg::IDX_W-1:0]  req_block_index,
   input  wire logic [bpec_pkg::SYM_W-1:0]  req_symbol,
   input  wire logic [bpec_pkg::WORD_W-1:0] req_eq_word,
   input  wire logic [bpec_pkg::IDX_W-1:0]  req_active_blocks_m1,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [bpec_pkg::IDX_W-1:0]  rsp_block_number,
   output logic      [bpec_pkg::WORD_W-1:0] rsp_pv_word,
   output logic      [bpec_pkg::WORD_W-1:0] rsp_mv_word,
   output logic                             rsp_carry_pos,
   output logic                             rsp_carry_neg,
   output logic                             rsp_last
);
   import bpec_pkg::*;

   localparam int EQ_DEPTH = WINDOW_BLOCKS * SYMBOLS;
   localparam int EAW      = $clog2(EQ_DEPTH);
   localparam int VAW      = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         blk_ff, blk_in;
   logic [SYM_W-1:0]         sym_ff, sym_in;
   logic                     hpos_ff, hpos_in;
   logic                     hneg_ff, hneg_in;
   logic [WINDOW_BLOCKS-1:0] vld_ff, vld_in;
   logic                     vld_rd_ff, vld_rd_in;

   logic                     out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]         out_blk_ff;
   step_type                 out_step_ff;
   logic                     out_last_ff;

   logic                     accept;
   logic                     do_load;
   logic                     do_start;
   logic                     do_adv;
   logic                     fire;
   logic                     is_last;
   logic [IDX_W-1:0]         blk_next;
   logic [IDX_W-1:0]         rd_blk;
   logic [SYM_W-1:0]         rd_sym;
   logic                     rd_en;
   logic [EAW-1:0]           eq_wr_addr;
   logic [EAW-1:0]           eq_rd_addr;
   logic [VAW-1:0]           vec_rd_addr;
   logic [VAW-1:0]           vec_wr_addr;
   logic [WORD_W-1:0]        eq_rd;
   logic [2*WORD_W-1:0]      vec_rd;
   logic [WORD_W-1:0]        pv_cur;
   logic [WORD_W-1:0]        mv_cur;
   logic [IDX_W-1:0]         start_count;
   step_type                 step;

   assign accept   = req_valid && req_ready;
   assign do_load  = accept && (req_cmd == CMD_LOAD)
                     && (int'(req_block_index) < WINDOW_BLOCKS);
   assign do_start = accept && (req_cmd == CMD_START);
   assign do_adv   = accept && (req_cmd == CMD_ADVANCE);
   assign fire     = (state_ff == ST_CALC) && (!out_valid_ff || rsp_ready);
   assign is_last  = (blk_ff == count_ff);
   assign blk_next = blk_ff + IDX_W'(1);

   assign start_count = (int'(req_active_blocks_m1) >= WINDOW_BLOCKS)
                        ? IDX_W'(WINDOW_BLOCKS - 1) : req_active_blocks_m1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_adv) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (fire && is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_blk    = blk_next;
      rd_sym    = sym_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_en     = do_adv;
            rd_blk    = '0;
            rd_sym    = req_symbol;
         end
         ST_CALC: begin
            rd_en = fire && !is_last;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign eq_wr_addr  = EAW'({req_block_index, req_symbol});
   assign eq_rd_addr  = EAW'({rd_blk, rd_sym});
   assign vec_rd_addr = VAW'(rd_blk);
   assign vec_wr_addr = VAW'(blk_ff);

   bpec_ram #(
      .WIDTH(WORD_W),
      .DEPTH(EQ_DEPTH)
   ) u_eq_ram (
      .clock  (clock),
      .wr_en  (do_load),
      .wr_addr(eq_wr_addr),
      .wr_data(req_eq_word),
      .rd_en  (rd_en),
      .rd_addr(eq_rd_addr),
      .rd_data(eq_rd)
   );

   bpec_ram #(
      .WIDTH(2 * WORD_W),
      .DEPTH(WINDOW_BLOCKS)
   ) u_vec_ram (
      .clock  (clock),
      .wr_en  (fire),
      .wr_addr(vec_wr_addr),
      .wr_data({step.pv, step.mv}),
      .rd_en  (rd_en),
      .rd_addr(vec_rd_addr),
      .rd_data(vec_rd)
   );

   assign pv_cur = vld_rd_ff ? vec_rd[2*WORD_W-1:WORD_W] : '1;
   assign mv_cur = vld_rd_ff ? vec_rd[WORD_W-1:0] : '0;

   bpec_column_step u_step (
      .eq_word(eq_rd),
      .pv_in  (pv_cur),
      .mv_in  (mv_cur),
      .hin_pos(hpos_ff),
      .hin_neg(hneg_ff),
      .res    (step)
   );

   always_comb begin
      count_in     = count_ff;
      blk_in       = blk_ff;
      sym_in       = sym_ff;
      hpos_in      = hpos_ff;
      hneg_in      = hneg_ff;
      vld_in       = vld_ff;
      vld_rd_in    = vld_rd_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (do_start) begin
         count_in = start_count;
         vld_in   = '0;
      end
      if (do_adv) begin
         blk_in  = '0;
         sym_in  = req_symbol;
         hpos_in = 1'b1;
         hneg_in = 1'b0;
      end
      if (rd_en) begin
         vld_rd_in = vld_ff[vec_rd_addr];
      end
      if (fire) begin
         vld_in[vec_wr_addr] = 1'b1;
         hpos_in             = step.carry_pos;
         hneg_in             = step.carry_neg;
         blk_in              = blk_next;
         out_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff    <= blk_in;
      sym_ff    <= sym_in;
      hpos_ff   <= hpos_in;
      hneg_ff   <= hneg_in;
      vld_rd_ff <= vld_rd_in;
      if (fire) begin
         out_blk_ff  <= blk_ff;
         out_step_ff <= step;
         out_last_ff <= is_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_block_number = out_blk_ff;
   assign rsp_pv_word      = out_step_ff.pv;
   assign rsp_mv_word      = out_step_ff.mv;
   assign rsp_carry_pos    = out_step_ff.carry_pos;
   assign rsp_carry_neg    = out_step_ff.carry_neg;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/core/bpec_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpec_ram #(
   parameter  int WIDTH = 64,
   parameter  int DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/bpec_column_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpec_column_step
// One Myers column update of a 64-row block with horizontal carry in/out.
// ----------------------------------------------------------------------------
module bpec_column_step (
   input  wire logic [bpec_pkg::WORD_W-1:0] eq_word,
   input  wire logic [bpec_pkg::WORD_W-1:0] pv_in,
   input  wire logic [bpec_pkg::WORD_W-1:0] mv_in,
   input  wire logic                        hin_pos,
   input  wire logic                        hin_neg,
   output bpec_pkg::step_type               res
);
   import bpec_pkg::*;

   logic [WORD_W-1:0] xv;
   logic [WORD_W-1:0] eqh;
   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] xh;
   logic [WORD_W-1:0] ph;
   logic [WORD_W-1:0] mh;
   logic [WORD_W-1:0] ph_sh;
   logic [WORD_W-1:0] mh_sh;

   always_comb begin
      xv    = eq_word | mv_in;
      eqh   = eq_word | {{(WORD_W-1){1'b0}}, hin_neg};
      sum   = (eqh & pv_in) + pv_in;
      xh    = (sum ^ pv_in) | eqh;
      ph    = mv_in | ~(xh | pv_in);
      mh    = pv_in & xh;
      ph_sh = {ph[WORD_W-2:0], hin_pos};
      mh_sh = {mh[WORD_W-2:0], hin_neg};
      res.pv        = mh_sh | ~(xv | ph_sh);
      res.mv        = ph_sh & xv;
      res.carry_pos = ph[WORD_W-1];
      res.carry_neg = mh[WORD_W-1];
   end

endmodule
`default_nettype wire

// File: tb/sv/bpec_column_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpec_column_checker
// Watches both channels of the edit column engine. Accepted requests
// update a local copy of the equality table, the per-block vertical vectors
// and the active span. An advance queues one expected column word per active
// block. Each accepted response is checked in order against that queue.
// ----------------------------------------------------------------------------
module bpec_column_checker
   import bpec_pkg::*;
#(
   parameter int WINDOW_BLOCKS = WINDOW_BLOCKS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [IDX_W-1:0]  req_block_index,
   input  wire logic [SYM_W-1:0]  req_symbol,
   input  wire logic [WORD_W-1:0] req_eq_word,
   input  wire logic [IDX_W-1:0]  req_active_blocks_m1,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [IDX_W-1:0]  rsp_block_number,
   input  wire logic [WORD_W-1:0] rsp_pv_word,
   input  wire logic [WORD_W-1:0] rsp_mv_word,
   input  wire logic              rsp_carry_pos,
   input  wire logic              rsp_carry_neg,
   input  wire logic              rsp_last,
   output logic [31:0]            fail_count,
   output logic [31:0]            pending_results,
   output logic [31:0]            checked_count
);

   typedef struct packed {
      logic [IDX_W-1:0]  block;
      logic [WORD_W-1:0] pv;
      logic [WORD_W-1:0] mv;
      logic              cp;
      logic              cn;
      logic              last;
   } column_word_type;

   logic [WORD_W-1:0] eq_words [WINDOW_BLOCKS*SYMBOLS];
   logic [WORD_W-1:0] pos_col  [WINDOW_BLOCKS];
   logic [WORD_W-1:0] neg_col  [WINDOW_BLOCKS];
   int unsigned       span_m1;
   column_word_type   column_words_q [$];
   column_word_type   got_word;
   column_word_type   want_word;
   int unsigned       mismatches = 0;
   int unsigned       checked    = 0;

   task automatic clear_columns();
      for (int b = 0; b < WINDOW_BLOCKS; b++) begin
         pos_col[b] = '1;
         neg_col[b] = '0;
      end
   endtask

   // one Myers step per active block, horizontal delta chained upwards
   task automatic advance_column(input logic [SYM_W-1:0] sym);
      logic [WORD_W-1:0] eq, pv, mv, xv, eqh, xh, ph, mh;
      logic              hp, hn, cp, cn;
      column_word_type   w;
      hp = 1'b1;
      hn = 1'b0;
      for (int b = 0; b <= span_m1 && b < WINDOW_BLOCKS; b++) begin
         eq  = eq_words[b*SYMBOLS + sym];
         pv  = pos_col[b];
         mv  = neg_col[b];
         xv  = eq | mv;
         eqh = eq | {{(WORD_W-1){1'b0}}, hn};
         xh  = (((eqh & pv) + pv) ^ pv) | eqh;
         ph  = mv | ~(xh | pv);
         mh  = pv & xh;
         cp  = ph[WORD_W-1];
         cn  = mh[WORD_W-1];
         ph  = {ph[WORD_W-2:0], hp};
         mh  = {mh[WORD_W-2:0], hn};
         pv  = mh | ~(xv | ph);
         mv  = ph & xv;
         pos_col[b] = pv;
         neg_col[b] = mv;
         w.block = IDX_W'(b);
         w.pv    = pv;
         w.mv    = mv;
         w.cp    = cp;
         w.cn    = cn;
         w.last  = (b == span_m1);
         column_words_q.push_back(w);
         hp = cp;
         hn = cn;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         column_words_q.delete();
         clear_columns();
         for (int i = 0; i < WINDOW_BLOCKS*SYMBOLS; i++) eq_words[i] = '0;
         span_m1 = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_word = '{rsp_block_number, rsp_pv_word, rsp_mv_word,
                         rsp_carry_pos, rsp_carry_neg, rsp_last};
            if (column_words_q.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected: blk %0d pv %h mv %h",
                        $time, got_word.block, got_word.pv, got_word.mv);
               $display("%0t:   cp %b cn %b last %b",
                        $time, got_word.cp, got_word.cn, got_word.last);
            end else begin
               want_word = column_words_q.pop_front();
               checked++;
               if (got_word !== want_word) begin
                  mismatches++;
                  $display("%0t: expected blk %0d pv %h mv %h cp %b cn %b last %b",
                           $time, want_word.block, want_word.pv, want_word.mv,
                           want_word.cp, want_word.cn, want_word.last);
                  $display("%0t:   actual blk %0d pv %h mv %h cp %b cn %b last %b",
                           $time, got_word.block, got_word.pv, got_word.mv,
                           got_word.cp, got_word.cn, got_word.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_cmd)
               CMD_LOAD: begin
                  if (req_block_index < WINDOW_BLOCKS)
                     eq_words[req_block_index*SYMBOLS + req_symbol] = req_eq_word;
               end
               CMD_START: begin
                  span_m1 = (req_active_blocks_m1 >= WINDOW_BLOCKS) ?
                            WINDOW_BLOCKS-1 : req_active_blocks_m1;
                  clear_columns();
               end
               CMD_ADVANCE: begin
                  advance_column(req_symbol);
               end
               default: begin
               end
            endcase
         end
      end
      fail_count      <= mismatches;
      pending_results <= column_words_q.size();
      checked_count   <= checked;
   end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the edit column engine. A short directed pass
// covers the field extremes, every command and the unused code; then random
// windows of start, table loads and text symbols, with noise in between.
// Both channels idle at random; one long response stall and one full drain
// are forced. Checking is done by bpec_column_checker.
// ----------------------------------------------------------------------------
module testbench;
   import bpec_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS  = 460;
   localparam int LONG_HOLD_AT = 220;
   localparam int LONG_HOLD    = 400;
   localparam int PAUSE_AT     = 330;

   logic              clock                = 1'b0;
   logic              reset                = 1'b1;
   logic              req_valid            = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd              = CMD_LOAD;
   logic [IDX_W-1:0]  req_block_index      = '0;
   logic [SYM_W-1:0]  req_symbol           = '0;
   logic [WORD_W-1:0] req_eq_word          = '0;
   logic [IDX_W-1:0]  req_active_blocks_m1 = '0;
   logic              rsp_valid;
   logic              rsp_ready            = 1'b0;
   logic [IDX_W-1:0]  rsp_block_number;
   logic [WORD_W-1:0] rsp_pv_word;
   logic [WORD_W-1:0] rsp_mv_word;
   logic              rsp_carry_pos;
   logic              rsp_carry_neg;
   logic              rsp_last;
   logic [31:0]       fail_count;
   logic [31:0]       pending_results;
   logic [31:0]       checked_count;

   int          sent_count    = 0;
   int          advance_count = 0;
   int          sender_calm   = 0;
   logic [31:0] loaded_mask   = '0;
   logic [2:0]  cur_span      = '0;

   always #5 clock = ~clock;

   bit_parallel_edit_column_engine u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_block_index      (req_block_index),
      .req_symbol           (req_symbol),
      .req_eq_word          (req_eq_word),
      .req_active_blocks_m1 (req_active_blocks_m1),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_block_number     (rsp_block_number),
      .rsp_pv_word          (rsp_pv_word),
      .rsp_mv_word          (rsp_mv_word),
      .rsp_carry_pos        (rsp_carry_pos),
      .rsp_carry_neg        (rsp_carry_neg),
      .rsp_last             (rsp_last)
   );

   bpec_column_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_block_index      (req_block_index),
      .req_symbol           (req_symbol),
      .req_eq_word          (req_eq_word),
      .req_active_blocks_m1 (req_active_blocks_m1),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_block_number     (rsp_block_number),
      .rsp_pv_word          (rsp_pv_word),
      .rsp_mv_word          (rsp_mv_word),
      .rsp_carry_pos        (rsp_carry_pos),
      .rsp_carry_neg        (rsp_carry_neg),
      .rsp_last             (rsp_last),
      .fail_count           (fail_count),
      .pending_results      (pending_results),
      .checked_count        (checked_count)
   );

   function automatic logic [WORD_W-1:0] rand_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 5))
         0:       w = '0;
         1:       w = '1;
         2:       w = 64'd1 << $urandom_range(0, 63);
         3:       w = {$urandom, $urandom} & {$urandom, $urandom};
         4:       w = {$urandom, $urandom} | {$urandom, $urandom};
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] blk,
                        input logic [SYM_W-1:0] sym, input logic [WORD_W-1:0] word,
                        input logic [IDX_W-1:0] span);
      int gap;
      int r;
      gap = 0;
      if (sender_calm > 0) begin
         sender_calm--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3)
            sender_calm = $urandom_range(20, 60);
         else if (r < 60)
            gap = 0;
         else if (r < 88)
            gap = $urandom_range(1, 3);
         else if (r < 97)
            gap = $urandom_range(4, 10);
         else
            gap = $urandom_range(20, 50);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_cmd              <= cmd;
      req_block_index      <= blk;
      req_symbol           <= sym;
      req_eq_word          <= word;
      req_active_blocks_m1 <= span;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (cmd == CMD_LOAD)
         loaded_mask[blk*SYMBOLS + sym] = 1'b1;
      else if (cmd == CMD_START)
         cur_span = span;
      else if (cmd == CMD_ADVANCE)
         advance_count++;
   endtask

   // loads any table entry the column would read before it was written
   task automatic column_step(input logic [SYM_W-1:0] sym);
      for (int b = 0; b <= cur_span; b++) begin
         if (!loaded_mask[b*SYMBOLS + sym])
            issue(CMD_LOAD, IDX_W'(b), sym, rand_word(), IDX_W'($urandom_range(0, 7)));
      end
      issue(CMD_ADVANCE, IDX_W'($urandom_range(0, 7)), sym, rand_word(),
            IDX_W'($urandom_range(0, 7)));
   endtask

   task automatic noise_request();
      issue(CMD_UNUSED, IDX_W'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 3)),
            rand_word(), IDX_W'($urandom_range(0, 7)));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // response side: short and long stalls, calm stretches, one long hold
   initial begin
      int  stall_left;
      int  calm_left;
      int  r;
      bit  long_hold_done;
      stall_left     = 0;
      calm_left      = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_ready     <= 1'b0;
            stall_left     = LONG_HOLD - 1;
         end else if (calm_left > 0) begin
            rsp_ready <= 1'b1;
            calm_left--;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20)
               stall_left = $urandom_range(1, 3);
            else if (r < 23)
               stall_left = $urandom_range(15, 60);
            else if (r < 26)
               calm_left = $urandom_range(30, 80);
         end
      end
   end

   initial begin
      #15000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int         r;
      int         cols;
      logic [2:0] span;
      logic [1:0] sym;
      bit         paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, word extremes, full window, unused code
      issue(CMD_LOAD, 3'd0, 2'd0, 64'h0, 3'd5);
      issue(CMD_LOAD, 3'd0, 2'd1, '1, 3'd2);
      issue(CMD_LOAD, 3'd0, 2'd2, 64'h5555_5555_5555_5555, 3'd7);
      issue(CMD_LOAD, 3'd0, 2'd3, 64'h8000_0000_0000_0001, 3'd0);
      column_step(2'd0);
      column_step(2'd1);
      column_step(2'd3);
      noise_request();
      issue(CMD_START, 3'd6, 2'd3, '1, 3'd7);
      for (int b = 1; b < 8; b++)
         issue(CMD_LOAD, IDX_W'(b), 2'd2, b[0] ? '1 : 64'hAAAA_AAAA_AAAA_AAAA, 3'd1);
      column_step(2'd2);
      column_step(2'd2);
      noise_request();
      issue(CMD_START, 3'd7, 2'd1, 64'h0, 3'd0);
      column_step(2'd1);

      while (sent_count < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            if (r < 8)
               span = 3'd7;
            else if (r < 14)
               span = 3'd0;
            else
               span = 3'($urandom_range(0, 7));
            issue(CMD_START, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  rand_word(), span);
            if ($urandom_range(0, 1)) begin
               sym = 2'($urandom_range(0, 3));
               for (int b = 0; b <= span; b++)
                  issue(CMD_LOAD, IDX_W'(b), sym, rand_word(), 3'($urandom_range(0, 7)));
            end
            cols = $urandom_range(1, 8);
            repeat (cols) begin
               if ($urandom_range(0, 9) == 0)
                  issue(CMD_LOAD, 3'($urandom_range(0, span)), 2'($urandom_range(0, 3)),
                        rand_word(), 3'($urandom_range(0, 7)));
               column_step(2'($urandom_range(0, 3)));
            end
         end else if (r < 85) begin
            noise_request();
         end else if (r < 92) begin
            issue(CMD_LOAD, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  rand_word(), 3'($urandom_range(0, 7)));
         end else if (r < 96) begin
            issue(CMD_START, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  rand_word(), 3'($urandom_range(0, 7)));
         end else begin
            column_step(2'($urandom_range(0, 3)));
         end
         if (!paused && sent_count >= PAUSE_AT) begin
            paused = 1'b1;
            wait_drain();
         end
      end

      wait_drain();
      repeat (16) @(posedge clock);
      $display("tb: %0d requests, %0d text symbols, %0d block words checked",
               sent_count, advance_count, checked_count);
      $display("tb: windows of one to eight blocks, long response stall and full drain");
      if (fail_count == 0 && pending_results == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
